// ===== rtl/ppe_pkg.sv =====
// Package for the palette pixel expander: shared constants, codes and the
// palette request struct. Used by every module in rtl/; depends on nothing.
package ppe_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_MAX_WIDTH   = 4096;

    // Configuration port.
    localparam int CFG_IW = 1;
    localparam int CFG_DW = 13;
    localparam logic [CFG_IW-1:0] CFG_DEPTH_MODE = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_ROW_WIDTH  = 1'b1;

    // Source depth codes; the unused code behaves as eight bits per pixel.
    localparam logic [1:0] DEPTH_1BPP = 2'd0;
    localparam logic [1:0] DEPTH_4BPP = 2'd1;
    localparam logic [1:0] DEPTH_8BPP = 2'd2;

    // Beat kinds carried in tuser.
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_ENTRY = 1'b1;

    localparam logic [1:0] RESET_DEPTH = DEPTH_8BPP;
    localparam int         RESET_WIDTH = 640;

    // Field widths fixed by the stream format.
    localparam int IDX_W   = 8;
    localparam int COLOR_W = 24;
    localparam int CNT_W   = 4;

    // Nibble mask and the top-bit mask used when unpacking a byte.
    localparam logic [7:0] NIBBLE_MASK = 8'd15;
    localparam logic [7:0] TOP_BIT     = 8'h80;

    // One palette access issued by the sequencer. The color word holds
    // red in the top byte and blue in the low byte.
    typedef struct packed {
        logic               rd;
        logic               wr;
        logic               last;
        logic [IDX_W-1:0]   index;
        logic [COLOR_W-1:0] color;
    } t_mem_req;

endpackage

// ===== rtl/palette_pixel_expander.sv =====
// Path: sequencer register, then palette read stage, then output register to the master side.
// Throughput: one pixel per cycle while the master side keeps up; a pixel beat holds the
// sequencer until its last pixel is issued, a palette write until it is issued. The single
// palette port, one read or one write a cycle, sets this rate.
// Reset: clears the sequencer, pipeline valids and column count; depth returns to eight bits
// per pixel and width to 640 (or MAX_WIDTH if smaller). Palette contents are undefined until written; no clearing pass.
module palette_pixel_expander #(
    parameter int TABLE_DEPTH = ppe_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_WIDTH   = ppe_pkg::DEF_MAX_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Slave side.
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata, lowest bit up: row_start[0], pixel_byte[8:1], entry_index[16:9],
    // entry_red[24:17], entry_green[32:25], entry_blue[40:33], zero fill[47:41].
    input  logic [47:0]                s_axis_tdata,
    // tuser: mode (0 pixel byte, 1 palette entry write).
    input  logic                       s_axis_tuser,
    // Master side.
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // tdata, lowest bit up: out_blue[7:0], out_green[15:8], out_red[23:16].
    output logic [23:0]                m_axis_tdata,
    // tlast: run_last, set on the last pixel produced from one byte.
    output logic                       m_axis_tlast,
    // Configuration write port.
    input  logic                       i_cfg_we,
    input  logic [ppe_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [ppe_pkg::CFG_DW-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int WW = (CW > ppe_pkg::CFG_DW) ? CW : ppe_pkg::CFG_DW;
    localparam int RESET_WIDTH_EFF =
        (ppe_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : ppe_pkg::RESET_WIDTH;

    // Configuration. The width is stored already clamped to MAX_WIDTH, so the
    // sequencer compares against it directly.
    logic [1:0]    r_depth;
    logic [CW-1:0] r_width;
    logic [WW-1:0] cfg_width_wide;

    assign cfg_width_wide = (WW'(i_cfg_data) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH)
                                                                : WW'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= ppe_pkg::RESET_DEPTH;
            r_width <= CW'(RESET_WIDTH_EFF);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ppe_pkg::CFG_DEPTH_MODE: r_depth <= i_cfg_data[1:0];
                ppe_pkg::CFG_ROW_WIDTH:  r_width <= cfg_width_wide[CW-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline: sequencer issues a palette access, the memory read stage holds
    // the looked-up color, and the output register feeds the master side. The
    // output register holds a pixel while the master side waits; once the read
    // stage is full too, reads stall. Accesses go out in beat order, one per
    // cycle unless stalled, so a palette write is always seen by every read
    // issued after it and by none issued before it; no forwarding is needed.
    ppe_pkg::t_mem_req           req;
    logic                        pal_valid;
    logic                        pal_last;
    logic [ppe_pkg::COLOR_W-1:0] pal_color;
    logic                        out_load;
    logic                        issue_ok;
    logic                        rd_adv;

    logic                        r_out_valid;
    logic                        r_out_last;
    logic [ppe_pkg::COLOR_W-1:0] r_out_color;

    assign out_load = !r_out_valid || m_axis_tready;
    assign rd_adv   = pal_valid && out_load;
    assign issue_ok = !pal_valid || out_load;

    ppe_seq #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_mode       (s_axis_tuser),
        .i_row_start  (s_axis_tdata[0]),
        .i_pixel_byte (s_axis_tdata[8:1]),
        .i_entry_index(s_axis_tdata[16:9]),
        .i_color      ({s_axis_tdata[24:17], s_axis_tdata[32:25], s_axis_tdata[40:33]}),
        .i_depth      (r_depth),
        .i_width      (r_width),
        .i_issue_ok   (issue_ok),
        .o_req        (req)
    );

    ppe_palette #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_palette (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .i_adv  (rd_adv),
        .o_valid(pal_valid),
        .o_last (pal_last),
        .o_color(pal_color)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= pal_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_last  <= pal_last;
            r_out_color <= pal_color;
        end
    end

    // The color word already holds blue in the low byte and red in the top byte.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = r_out_color;

    // The single palette port never sees a read and a write in the same cycle.
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(req.rd && req.wr))
        else $error("palette read and write issued together");

    // A read is issued only when the read stage can take its data.
    a_read_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.rd |-> issue_ok)
        else $error("palette read issued into a stalled read stage");

    // A stalled read stage keeps its pixel until the output register takes it.
    a_read_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pal_valid && !out_load) |=> (pal_valid && $stable(pal_last) && $stable(pal_color)))
        else $error("stalled palette read data changed");

    // The sequencer issues nothing while it reports itself free and idle of work.
    a_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req.rd || req.wr) |-> !s_axis_tready || req.last || req.wr)
        else $error("access issued by an idle sequencer");

endmodule

// ===== rtl/ppe_seq.sv =====
// Beat sequencer of the palette pixel expander: accepts beats, tracks the
// column, and issues one palette read or write per cycle while reads are not stalled. Uses ppe_pkg.
module ppe_seq #(
    parameter int MAX_WIDTH = ppe_pkg::DEF_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_mode,
    input  logic                        i_row_start,
    input  logic [7:0]                  i_pixel_byte,
    input  logic [ppe_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [ppe_pkg::COLOR_W-1:0] i_color,
    input  logic [1:0]                  i_depth,
    input  logic [CW-1:0]               i_width,
    input  logic                        i_issue_ok,
    output ppe_pkg::t_mem_req           o_req
);

    logic                        r_busy;
    logic                        r_write;
    logic [7:0]                  r_byte;
    logic [ppe_pkg::CNT_W-1:0]   r_cnt;
    logic [CW-1:0]               r_col;
    logic [ppe_pkg::IDX_W-1:0]   r_entry;
    logic [ppe_pkg::COLOR_W-1:0] r_color;

    logic                        issue;
    logic                        done;
    logic                        accept;
    logic [CW-1:0]               col_base;
    logic [CW-1:0]               avail;
    logic [ppe_pkg::CNT_W-1:0]   npix;
    logic [ppe_pkg::CNT_W-1:0]   cnt;
    logic [7:0]                  pix_index;
    logic [7:0]                  byte_shifted;

    assign issue   = r_busy && (r_write || i_issue_ok);
    assign done    = issue && (r_write || r_cnt == ppe_pkg::CNT_W'(1));
    assign o_ready = !r_busy || done;
    assign accept  = i_valid && o_ready;

    // Pixels that fit between the column and the row width.
    always_comb begin
        col_base = i_row_start ? '0 : r_col;
        avail    = i_width - col_base;
        unique case (i_depth)
            ppe_pkg::DEPTH_1BPP: npix = ppe_pkg::CNT_W'(8);
            ppe_pkg::DEPTH_4BPP: npix = ppe_pkg::CNT_W'(2);
            default:             npix = ppe_pkg::CNT_W'(1);
        endcase
        if (col_base >= i_width) begin
            cnt = '0;
        end else if (avail < CW'(npix)) begin
            cnt = avail[ppe_pkg::CNT_W-1:0];
        end else begin
            cnt = npix;
        end
    end

    // The current pixel always sits in the top bits of the shifted byte.
    always_comb begin
        unique case (i_depth)
            ppe_pkg::DEPTH_1BPP: begin
                pix_index    = ((r_byte & ppe_pkg::TOP_BIT) != 8'd0) ? 8'd1 : 8'd0;
                byte_shifted = r_byte << 1;
            end
            ppe_pkg::DEPTH_4BPP: begin
                pix_index    = (r_byte >> 4) & ppe_pkg::NIBBLE_MASK;
                byte_shifted = r_byte << 4;
            end
            default: begin
                pix_index    = r_byte;
                byte_shifted = r_byte;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_col  <= '0;
        end else if (accept) begin
            if (i_mode == ppe_pkg::MODE_ENTRY) begin
                r_busy <= 1'b1;
            end else begin
                r_busy <= (cnt != '0);
                r_col  <= col_base + CW'(cnt);
            end
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_write <= (i_mode == ppe_pkg::MODE_ENTRY);
            r_byte  <= i_pixel_byte;
            r_cnt   <= cnt;
            r_entry <= i_entry_index;
            r_color <= i_color;
        end else if (issue && !r_write) begin
            r_byte <= byte_shifted;
            r_cnt  <= r_cnt - ppe_pkg::CNT_W'(1);
        end
    end

    always_comb begin
        o_req.rd    = issue && !r_write;
        o_req.wr    = issue && r_write;
        o_req.last  = (r_cnt == ppe_pkg::CNT_W'(1));
        o_req.index = r_write ? r_entry : pix_index;
        o_req.color = r_color;
    end

endmodule

// ===== rtl/ppe_palette.sv =====
// Color table of the palette pixel expander: one synchronous memory with a
// registered read port and its read stage. Uses ppe_pkg::t_mem_req.
module ppe_palette #(
    parameter int TABLE_DEPTH = ppe_pkg::DEF_TABLE_DEPTH,
    localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ppe_pkg::t_mem_req           i_req,
    input  logic                        i_adv,
    output logic                        o_valid,
    output logic                        o_last,
    output logic [ppe_pkg::COLOR_W-1:0] o_color
);

    logic [ppe_pkg::COLOR_W-1:0] mem [TABLE_DEPTH];
    logic [ppe_pkg::COLOR_W-1:0] r_q;
    logic                        r_valid;
    logic                        r_last;
    logic                        r_zero;
    logic                        in_range;
    logic [AW-1:0]               addr;

    // Indexes past the table write nothing and read as the zero color.
    assign in_range = {1'b0, i_req.index} < (ppe_pkg::IDX_W + 1)'(TABLE_DEPTH);
    assign addr     = i_req.index[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.wr && in_range) begin
            mem[addr] <= i_req.color;
        end
        if (i_req.rd) begin
            r_q <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_last <= i_req.last;
            r_zero <= !in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.rd) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_color = r_zero ? '0 : r_q;

endmodule
